// ===== hw/rtl/fisf_pkg.sv =====
package fisf_pkg;

  // frame bytes
  localparam logic [7:0] FLAG_BYTE  = 8'h7E;
  localparam logic [7:0] ESC_BYTE   = 8'h7D;
  localparam logic [7:0] ESC_FLAG   = 8'h5E;
  localparam logic [7:0] ESC_ESC    = 8'h5D;
  localparam logic [7:0] CTRL_SEQ0  = 8'h00;
  localparam logic [7:0] CTRL_SEQ1  = 8'h40;
  localparam logic [7:0] ADDR_RESET = 8'h03;

  // request commands
  localparam logic CMD_PAYLOAD = 1'b0;
  localparam logic CMD_REPORT  = 1'b1;

  // register map
  localparam int PADDR_W = 3;
  localparam logic [PADDR_W-1:0] REG_ADDRESS_BYTE = 3'd0;

  // job queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // one payload byte, classified by the front
  typedef struct packed {
    logic       hdr;
    logic [7:0] addr;
    logic [7:0] ctrl;
    logic [7:0] data;
    logic       last;
    logic [7:0] chk;
  } job_t;

  typedef struct packed {
    logic                   full;
    logic                   empty;
    logic [QUEUE_CNT_W-1:0] count;
  } queue_status_t;

  typedef struct packed {
    logic seq_bit;
    logic frame_open;
  } front_status_t;

  // byte the back emits next for the job at the queue head
  typedef enum logic [3:0] {
    PH_FLAG,
    PH_ADDR,
    PH_CTRL,
    PH_HCHK,
    PH_DATA,
    PH_DATA2,
    PH_CHK,
    PH_CHK2,
    PH_END
  } phase_t;

  function automatic logic needs_escape(input logic [7:0] b);
    return (b == FLAG_BYTE) || (b == ESC_BYTE);
  endfunction

  function automatic logic [7:0] escaped_code(input logic [7:0] b);
    return (b == FLAG_BYTE) ? ESC_FLAG : ESC_ESC;
  endfunction

endpackage

// ===== hw/rtl/fisf_front.sv =====
module fisf_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    command,
  input  logic [7:0]              data_byte,
  input  logic                    last_byte,
  input  logic                    ack_sequence,
  input  logic [7:0]              address_byte,
  input  fisf_pkg::queue_status_t q_status,
  output logic                    push,
  output fisf_pkg::job_t          push_job,
  output fisf_pkg::front_status_t status
);

  logic       seq_bit;
  logic       frame_open;
  logic [7:0] check_accumulator;
  logic       accept;
  logic [7:0] chk_new;

  // take a request whenever the queue has room
  assign in_stall = q_status.full;
  assign accept   = in_valid && !q_status.full;
  assign push     = accept && (command == fisf_pkg::CMD_PAYLOAD);

  // running check restarts with each new frame
  assign chk_new = (frame_open ? check_accumulator : 8'h00) ^ data_byte;

  // job descriptor for the back
  always_comb begin
    push_job.hdr  = !frame_open;
    push_job.addr = address_byte;
    push_job.ctrl = seq_bit ? fisf_pkg::CTRL_SEQ1 : fisf_pkg::CTRL_SEQ0;
    push_job.data = data_byte;
    push_job.last = last_byte;
    push_job.chk  = chk_new;
  end

  // frame and sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_bit           <= 1'b0;
      frame_open        <= 1'b0;
      check_accumulator <= 8'h00;
    end else if (accept) begin
      if (command == fisf_pkg::CMD_REPORT) begin
        if (ack_sequence != seq_bit) begin
          seq_bit <= !seq_bit;
        end
      end else begin
        frame_open        <= !last_byte;
        check_accumulator <= last_byte ? 8'h00 : chk_new;
      end
    end
  end

  assign status.seq_bit    = seq_bit;
  assign status.frame_open = frame_open;

endmodule

// ===== hw/rtl/fisf_queue.sv =====
module fisf_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  fisf_pkg::job_t          push_job,
  input  logic                    pop,
  output fisf_pkg::job_t          head,
  output fisf_pkg::queue_status_t status
);

  fisf_pkg::job_t                       entries [fisf_pkg::QUEUE_DEPTH];
  logic [fisf_pkg::QUEUE_IDX_W-1:0]     wr_ptr;
  logic [fisf_pkg::QUEUE_IDX_W-1:0]     rd_ptr;
  logic [fisf_pkg::QUEUE_CNT_W-1:0]     count;

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head         = entries[rd_ptr];
  assign status.count = count;
  assign status.empty = (count == '0);
  assign status.full  = (count == fisf_pkg::QUEUE_CNT_W'(fisf_pkg::QUEUE_DEPTH));

endmodule

// ===== hw/rtl/fisf_back.sv =====
module fisf_back (
  input  logic                    clk,
  input  logic                    rst,
  input  fisf_pkg::job_t          head,
  input  fisf_pkg::queue_status_t q_status,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [7:0]              out_byte,
  output logic                    frame_end
);

  fisf_pkg::phase_t phase;
  fisf_pkg::phase_t eff_phase;
  fisf_pkg::phase_t phase_after;
  logic             advance;
  logic             go;
  logic             done;
  logic [7:0]       byte_next;
  logic             end_next;

  // output register frees up when empty or being taken
  assign advance = !out_valid || !out_stall;
  assign go      = advance && !q_status.empty;
  assign pop     = go && done;

  // a job without header starts at its data byte
  assign eff_phase = ((phase == fisf_pkg::PH_FLAG) && !head.hdr) ? fisf_pkg::PH_DATA : phase;

  // byte selection and sequencing
  always_comb begin
    byte_next   = fisf_pkg::FLAG_BYTE;
    end_next    = 1'b0;
    phase_after = fisf_pkg::PH_FLAG;
    done        = 1'b0;
    case (eff_phase)
      fisf_pkg::PH_FLAG: begin
        byte_next   = fisf_pkg::FLAG_BYTE;
        phase_after = fisf_pkg::PH_ADDR;
      end
      fisf_pkg::PH_ADDR: begin
        byte_next   = head.addr;
        phase_after = fisf_pkg::PH_CTRL;
      end
      fisf_pkg::PH_CTRL: begin
        byte_next   = head.ctrl;
        phase_after = fisf_pkg::PH_HCHK;
      end
      fisf_pkg::PH_HCHK: begin
        byte_next   = head.addr ^ head.ctrl;
        phase_after = fisf_pkg::PH_DATA;
      end
      fisf_pkg::PH_DATA: begin
        if (fisf_pkg::needs_escape(head.data)) begin
          byte_next   = fisf_pkg::ESC_BYTE;
          phase_after = fisf_pkg::PH_DATA2;
        end else begin
          byte_next   = head.data;
          phase_after = fisf_pkg::PH_CHK;
          done        = !head.last;
        end
      end
      fisf_pkg::PH_DATA2: begin
        byte_next   = fisf_pkg::escaped_code(head.data);
        phase_after = fisf_pkg::PH_CHK;
        done        = !head.last;
      end
      fisf_pkg::PH_CHK: begin
        if (fisf_pkg::needs_escape(head.chk)) begin
          byte_next   = fisf_pkg::ESC_BYTE;
          phase_after = fisf_pkg::PH_CHK2;
        end else begin
          byte_next   = head.chk;
          phase_after = fisf_pkg::PH_END;
        end
      end
      fisf_pkg::PH_CHK2: begin
        byte_next   = fisf_pkg::escaped_code(head.chk);
        phase_after = fisf_pkg::PH_END;
      end
      fisf_pkg::PH_END: begin
        byte_next = fisf_pkg::FLAG_BYTE;
        end_next  = 1'b1;
        done      = 1'b1;
      end
      default: begin
        byte_next = fisf_pkg::FLAG_BYTE;
        done      = 1'b1;
      end
    endcase
  end

  // phase register and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= fisf_pkg::PH_FLAG;
      out_valid <= 1'b0;
    end else begin
      if (go) begin
        phase <= done ? fisf_pkg::PH_FLAG : phase_after;
      end
      if (advance) begin
        out_valid <= !q_status.empty;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (go) begin
      out_byte  <= byte_next;
      frame_end <= end_next;
    end
  end

endmodule

// ===== hw/rtl/info_frame_stuffing_framer.sv =====
// channel   direction  handshake            payload
// in        input      in_valid / in_stall  command, data_byte, last_byte, ack_sequence
// out       output     out_valid / out_stall out_byte, frame_end
// cfg       input      APB psel/penable     paddr, pwdata, prdata, pready
//
// One output byte per cycle from the back sequencer while the queue holds a job and
// out_stall is low; a payload request yields 1 to 9 bytes, so a plain payload byte
// inside a frame gives one byte and a stuffed one two; the front absorbs reports.
// A 4-entry job queue lets requests enter while earlier bytes still drain.
// rst is synchronous; it clears frame state, sequence bit, queue and output valid,
// and sets address_byte to 3. Output stall holds the byte; a full queue raises in_stall.
module info_frame_stuffing_framer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         command,
  input  logic [7:0]                   data_byte,
  input  logic                         last_byte,
  input  logic                         ack_sequence,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   out_byte,
  output logic                         frame_end,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fisf_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  logic                    [7:0] address_byte;
  logic                          push;
  logic                          pop;
  fisf_pkg::job_t                push_job;
  fisf_pkg::job_t                head;
  fisf_pkg::queue_status_t       q_status;
  fisf_pkg::front_status_t       f_status;

  // configuration register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      address_byte <= fisf_pkg::ADDR_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr == fisf_pkg::REG_ADDRESS_BYTE)) begin
      address_byte <= pwdata[7:0];
    end
  end
  assign prdata = (paddr == fisf_pkg::REG_ADDRESS_BYTE) ? {24'h000000, address_byte} : 32'h0;

  // accept and classify
  fisf_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .ack_sequence (ack_sequence),
    .address_byte (address_byte),
    .q_status     (q_status),
    .push         (push),
    .push_job     (push_job),
    .status       (f_status)
  );

  // job queue
  fisf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  // byte sequencer
  fisf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .frame_end (frame_end)
  );

  // closing marker only on a flag byte
  a_end_is_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> out_byte == fisf_pkg::FLAG_BYTE)
    else $error("frame_end on a non-flag byte");

  // sequence bit moves only on an accepted report
  a_seq_only_on_report: assert property (@(posedge clk) disable iff (rst)
    !(in_valid && !in_stall && command == fisf_pkg::CMD_REPORT) |=> $stable(f_status.seq_bit))
    else $error("sequence bit changed without a report");

  // input stalls only against a full queue
  a_stall_means_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> q_status.count == fisf_pkg::QUEUE_CNT_W'(fisf_pkg::QUEUE_DEPTH))
    else $error("input stalled with room in the queue");

  // no new frame header while a frame is open in the front
  a_no_header_in_frame: assert property (@(posedge clk) disable iff (rst)
    push && f_status.frame_open |-> !push_job.hdr)
    else $error("header queued inside an open frame");

endmodule
